// ----- src/hsl_pkg.sv -----
// Shared constants for the HSL to RGB converter.
package hsl_pkg;

  localparam int DEF_FRAC_BITS = 12;
  localparam int STAGES        = 6;
  localparam int RGB_BITS      = 8;

endpackage

// ----- src/hsl_in_if.sv -----
// Request channel carrying one HSL pixel.
interface hsl_in_if
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   lightness;

  modport source (output valid, output hue, output saturation, output lightness, input ready);
  modport sink (input valid, input hue, input saturation, input lightness, output ready);
endinterface

// ----- src/hsl_out_if.sv -----
// Request channel carrying one RGB pixel.
interface hsl_out_if
  import hsl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RGB_BITS-1:0] red;
  logic [RGB_BITS-1:0] green;
  logic [RGB_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- src/hsl_to_rgb.sv -----
// Top level of the pipelined HSL to RGB pixel converter.
//
//   Channel  Role    Payload
//   hsl      input   hue, saturation, lightness
//   rgb      output  red, green, blue
//
// Six register stages. One pixel per cycle is sustained while the output is ready;
// each stage holds its request while the stage after it is full and stalled, and
// empty stages still take new data.
// Reset empties the pipeline; the input is not ready during reset.
module hsl_to_rgb
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
)(
  input logic       clk,
  input logic       rst,
  hsl_in_if.sink    hsl,
  hsl_out_if.source rgb
);

  logic [STAGES-1:0]    en;
  logic [FRAC_BITS+1:0] t_red;
  logic [FRAC_BITS+1:0] t_green;
  logic [FRAC_BITS+1:0] t_blue;
  logic [2*FRAC_BITS:0] p2;
  logic [2*FRAC_BITS:0] diff;

  hsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsl.valid),
    .in_ready  (hsl.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .en        (en)
  );

  hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .en         (en),
    .hue        (hsl.hue),
    .saturation (hsl.saturation),
    .lightness  (hsl.lightness),
    .t_red      (t_red),
    .t_green    (t_green),
    .t_blue     (t_blue),
    .p2         (p2),
    .diff       (diff)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk   (clk),
    .en    (en),
    .t     (t_red),
    .p2    (p2),
    .diff  (diff),
    .level (rgb.red)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk   (clk),
    .en    (en),
    .t     (t_green),
    .p2    (p2),
    .diff  (diff),
    .level (rgb.green)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk   (clk),
    .en    (en),
    .t     (t_blue),
    .p2    (p2),
    .diff  (diff),
    .level (rgb.blue)
  );

endmodule

// ----- src/hsl_ctrl.sv -----
// Valid bits and per-stage load enables for the conversion pipeline.
module hsl_ctrl
  import hsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] en
);

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] up;
  logic [STAGES-1:0] rdy;

  always_comb begin
    up[0] = in_valid;
    for (int k = 1; k < STAGES; k++) begin
      up[k] = valid[k-1];
    end
    rdy[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
    en = up & rdy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          valid[k] <= up[k];
        end
      end
    end
  end

  assign in_ready  = rdy[0] && !rst;
  assign out_valid = valid[STAGES-1];

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  a_reset_empty: assert property (@(posedge clk) rst |=> valid == '0)
    else $error("pipeline not empty after reset");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(in_fire) && !$past(out_fire)
      |-> $countones(valid) == $past($countones(valid)))
    else $error("request count changed without a transfer");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(in_fire) && !$past(out_fire)
      |-> $countones(valid) == $past($countones(valid)) + 1)
    else $error("accepted request was lost");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    valid != {STAGES{1'b1}} |-> in_ready)
    else $error("input stalled while the pipeline has a free stage");

endmodule

// ----- src/hsl_front.sv -----
// Clamping, lightness by saturation product, q and p, and hue ramp positions.
module hsl_front
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
)(
  input  logic                 clk,
  input  logic [STAGES-1:0]    en,
  input  logic [FRAC_BITS-1:0] hue,
  input  logic [FRAC_BITS:0]   saturation,
  input  logic [FRAC_BITS:0]   lightness,
  output logic [FRAC_BITS+1:0] t_red,
  output logic [FRAC_BITS+1:0] t_green,
  output logic [FRAC_BITS+1:0] t_blue,
  output logic [2*FRAC_BITS:0] p2,
  output logic [2*FRAC_BITS:0] diff
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0]   ONE_S   = (F+1)'(1 << F);
  localparam logic [F:0]   HALF_S  = (F+1)'(1 << (F - 1));
  localparam logic [F+2:0] ONE_X   = (F+3)'(1 << F);
  localparam logic [F+2:0] TWO_X   = (F+3)'(2 << F);
  localparam logic [F+2:0] THREE_X = (F+3)'(3 << F);

  logic [F:0]     s_cl;
  logic [F:0]     l_cl;
  logic [F+2:0]   h3x;
  logic [F+2:0]   r_sum;
  logic [F+2:0]   b_sum;
  logic [F+2:0]   r_wrap;
  logic [F+2:0]   b_wrap;

  logic [F:0]     l1;
  logic [F:0]     s1;
  logic [2*F+1:0] ls1;
  logic [F+1:0]   tr1;
  logic [F+1:0]   tg1;
  logic [F+1:0]   tb1;

  logic [2*F+1:0] q_lo;
  logic [2*F+1:0] q_hi;
  logic [2*F+1:0] q_full;
  logic [2*F:0]   q2;
  logic [F:0]     l2;

  logic [2*F+1:0] two_l;
  logic [2*F+1:0] p_full;
  logic [2*F+1:0] d_full;

  always_comb begin
    s_cl   = (saturation > ONE_S) ? ONE_S : saturation;
    l_cl   = (lightness > ONE_S) ? ONE_S : lightness;
    h3x    = (F+3)'({hue, 1'b0}) + (F+3)'(hue);
    r_sum  = h3x + ONE_X;
    b_sum  = h3x + TWO_X;
    r_wrap = (r_sum >= THREE_X) ? r_sum - THREE_X : r_sum;
    b_wrap = (b_sum >= THREE_X) ? b_sum - THREE_X : b_sum;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l1  <= l_cl;
      s1  <= s_cl;
      ls1 <= (2*F+2)'(l_cl) * (2*F+2)'(s_cl);
      tr1 <= r_wrap[F+1:0];
      tg1 <= h3x[F+1:0];
      tb1 <= b_wrap[F+1:0];
    end
  end

  always_comb begin
    q_lo   = {1'b0, l1, {F{1'b0}}} + ls1;
    q_hi   = {(F+2)'(l1) + (F+2)'(s1), {F{1'b0}}} - ls1;
    q_full = (l1 < HALF_S) ? q_lo : q_hi;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q2      <= q_full[2*F:0];
      l2      <= l1;
      t_red   <= tr1;
      t_green <= tg1;
      t_blue  <= tb1;
    end
  end

  always_comb begin
    two_l  = {l2, {(F+1){1'b0}}};
    p_full = two_l - {1'b0, q2};
    d_full = {q2, 1'b0} - two_l;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2   <= p_full[2*F:0];
      diff <= d_full[2*F:0];
    end
  end

endmodule

// ----- src/hsl_chan.sv -----
// One colour channel: hue ramp weight, scaling by the q to p span, and rounding.
module hsl_chan
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
)(
  input  logic                 clk,
  input  logic [STAGES-1:0]    en,
  input  logic [FRAC_BITS+1:0] t,
  input  logic [2*FRAC_BITS:0] p2,
  input  logic [2*FRAC_BITS:0] diff,
  output logic [RGB_BITS-1:0]  level
);

  localparam int F = FRAC_BITS;
  localparam logic [F+2:0]   ONE_X   = (F+3)'(1 << F);
  localparam logic [F+2:0]   THREE_X = (F+3)'(3 << F);
  localparam logic [F+2:0]   FOUR_X  = (F+3)'(4 << F);
  localparam logic [3*F+8:0] RND     = (3*F+9)'(1) << (3*F - 1);

  logic [F+2:0]   t2x;
  logic [F+2:0]   fall;
  logic [F:0]     weight;
  logic [F:0]     fac;
  logic [3*F:0]   prod;
  logic [2*F:0]   p2_d;
  logic [3*F:0]   c3;
  logic [3*F+8:0] scaled;

  // The weight is the ramp height in units of the q to p span, at scale one.
  always_comb begin
    t2x  = {t, 1'b0};
    fall = FOUR_X - t2x;
    if (t2x < ONE_X) begin
      weight = t2x[F:0];
    end else if (t2x < THREE_X) begin
      weight = ONE_X[F:0];
    end else if (t2x < FOUR_X) begin
      weight = fall[F:0];
    end else begin
      weight = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fac <= weight;
    end
    if (en[3]) begin
      prod <= (3*F+1)'((3*F+2)'(diff) * (3*F+2)'(fac));
      p2_d <= p2;
    end
    if (en[4]) begin
      c3 <= {p2_d, {F{1'b0}}} + prod;
    end
    if (en[5]) begin
      level <= scaled[3*F+7:3*F];
    end
  end

  assign scaled = {c3, 8'b0} - (3*F+9)'(c3) + RND;

endmodule

// ----- sim/hsl_to_rgb_tb.sv -----
// Self-checking testbench for the HSL to RGB pixel converter.
`timescale 1ns / 100ps

module hsl_to_rgb_tb;
  import hsl_pkg::*;

  localparam int FRAC_BITS   = DEF_FRAC_BITS;
  localparam int ONE_LEVEL   = 1 << FRAC_BITS;
  localparam int SCALE_SHIFT = 3 * FRAC_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int RANDOM_PIXELS = 1050;

  typedef struct packed {
    bit [FRAC_BITS-1:0] hue;
    bit [FRAC_BITS:0]   saturation;
    bit [FRAC_BITS:0]   lightness;
  } hsl_pixel_t;

  typedef struct packed {
    bit [RGB_BITS-1:0] red;
    bit [RGB_BITS-1:0] green;
    bit [RGB_BITS-1:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    hsl_pixel_t pixel;
    bit         typed;
    rgb_pixel_t rgb;
  } stim_row_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   hold_requests;
  rgb_pixel_t pending_rgb_q [$];

  hsl_in_if #(.FRAC_BITS(FRAC_BITS)) hsl_bus ();
  hsl_out_if rgb_bus ();

  hsl_to_rgb #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk (clk),
    .rst (rst),
    .hsl (hsl_bus),
    .rgb (rgb_bus)
  );

  // Rows with a typed result can be read straight off the conversion rules.
  stim_row_t directed_rows [24] = '{
    '{'{12'd0,    13'd0,    13'd0},    1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd0,    13'd0,    13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{12'd0,    13'd0,    13'd2048}, 1'b1, '{8'd128, 8'd128, 8'd128}},
    '{'{12'd4095, 13'd0,    13'd8191}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{12'd0,    13'd4096, 13'd2048}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{12'd0,    13'd8191, 13'd2048}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{12'd0,    13'd4096, 13'd0},    1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd2048, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{12'd2048, 13'd4096, 13'd2048}, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{'{12'd4095, 13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd682,  13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd683,  13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd1365, 13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd1366, 13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd2730, 13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd2731, 13'd4096, 13'd2048}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd1024, 13'd2048, 13'd1024}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd3072, 13'd1,    13'd2047}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd1000, 13'd4097, 13'd3000}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd2500, 13'd4096, 13'd4097}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'hAAA,  13'h0555, 13'h0AAA}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'h555,  13'h1AAA, 13'h1555}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd300,  13'd1,    13'd1},    1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{12'd3500, 13'd4095, 13'd4095}, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  function automatic bit [63:0] clamp_level(bit [FRAC_BITS:0] level);
    return (level > ONE_LEVEL) ? 64'(ONE_LEVEL) : 64'(level);
  endfunction

  // Ramp position is three times the hue turn, in units of one level.
  function automatic bit [63:0] hue_ramp_level(bit [63:0] p2, bit [63:0] q2, bit [63:0] t3);
    bit [63:0] one;
    bit [63:0] base;
    one  = 64'(ONE_LEVEL);
    base = p2 * one;
    if (2 * t3 < one) begin
      return base + (q2 - p2) * (2 * t3);
    end
    if (2 * t3 < 3 * one) begin
      return q2 * one;
    end
    if (t3 < 2 * one) begin
      return base + (q2 - p2) * (4 * one - 2 * t3);
    end
    return base;
  endfunction

  function automatic bit [RGB_BITS-1:0] round_to_byte(bit [63:0] c3);
    bit [63:0] r;
    r = (c3 * 255 + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
    return (r > 255) ? 8'd255 : r[RGB_BITS-1:0];
  endfunction

  function automatic rgb_pixel_t hsl_pixel_to_rgb(hsl_pixel_t px);
    bit [63:0] one;
    bit [63:0] h3;
    bit [63:0] s;
    bit [63:0] l;
    bit [63:0] q2;
    bit [63:0] p2;
    rgb_pixel_t res;
    one = 64'(ONE_LEVEL);
    h3  = 3 * 64'(px.hue);
    s   = clamp_level(px.saturation);
    l   = clamp_level(px.lightness);
    if (s == 0) begin
      res.red   = round_to_byte(l * one * one);
      res.green = res.red;
      res.blue  = res.red;
      return res;
    end
    if (2 * l < one) begin
      q2 = l * (one + s);
    end else begin
      q2 = (l + s) * one - l * s;
    end
    p2 = 2 * l * one - q2;
    res.red   = round_to_byte(hue_ramp_level(p2, q2, (h3 + one) % (3 * one)));
    res.green = round_to_byte(hue_ramp_level(p2, q2, h3));
    res.blue  = round_to_byte(hue_ramp_level(p2, q2, (h3 + 2 * one) % (3 * one)));
    return res;
  endfunction

  function automatic bit [FRAC_BITS:0] random_level(int unsigned style);
    int corners [7];
    corners = '{0, 1, ONE_LEVEL / 2 - 1, ONE_LEVEL / 2, ONE_LEVEL - 1, ONE_LEVEL,
                2 * ONE_LEVEL - 1};
    case (style)
      0: begin
        return (FRAC_BITS+1)'($urandom_range(0, 2 * ONE_LEVEL - 1));
      end
      1: begin
        return (FRAC_BITS+1)'(corners[$urandom_range(0, 6)]);
      end
      default: begin
        return (FRAC_BITS+1)'($urandom_range(0, ONE_LEVEL));
      end
    endcase
  endfunction

  task automatic offer_pixel(input hsl_pixel_t px, input bit typed, input rgb_pixel_t rgb);
    hsl_bus.valid      <= 1'b1;
    hsl_bus.hue        <= px.hue;
    hsl_bus.saturation <= px.saturation;
    hsl_bus.lightness  <= px.lightness;
    @(posedge clk);
    while (!hsl_bus.ready) begin
      @(posedge clk);
    end
    pending_rgb_q.push_back(typed ? rgb : hsl_pixel_to_rgb(px));
    @(negedge clk);
  endtask

  task automatic compare_channel(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin : rgb_check
    rgb_pixel_t want;
    if (!rst && rgb_bus.valid && rgb_bus.ready) begin
      if (pending_rgb_q.size() == 0) begin
        $error("unexpected RGB request: red %0d green %0d blue %0d",
               rgb_bus.red, rgb_bus.green, rgb_bus.blue);
        fail_count++;
      end else begin
        want = pending_rgb_q.pop_front();
        compare_channel("red", int'(want.red), int'(rgb_bus.red));
        compare_channel("green", int'(want.green), int'(rgb_bus.green));
        compare_channel("blue", int'(want.blue), int'(rgb_bus.blue));
      end
    end
  end

  initial begin : rgb_receiver
    int cycle;
    int hold_left;
    int holds_served;
    bit take;
    cycle         = 0;
    hold_left     = 0;
    holds_served  = 0;
    rgb_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case ((cycle / 97) % 4)
          0: begin
            take = 1'b1;
          end
          1: begin
            take = ($urandom_range(0, 1) == 0);
          end
          2: begin
            take = (cycle % 4 != 0);
          end
          default: begin
            take = ($urandom_range(0, 9) == 0);
          end
        endcase
      end
      rgb_bus.ready <= take;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((hsl_bus.valid && hsl_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    hsl_pixel_t px;
    rgb_pixel_t none;
    int unsigned style;
    int burst_left;
    int gap;
    fail_count         = 0;
    hold_requests      = 0;
    none               = '0;
    rst                = 1'b1;
    hsl_bus.valid      = 1'b0;
    hsl_bus.hue        = '0;
    hsl_bus.saturation = '0;
    hsl_bus.lightness  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_pixel(directed_rows[i].pixel, directed_rows[i].typed, directed_rows[i].rgb);
      if (i % 3 == 2) begin
        hsl_bus.valid <= 1'b0;
        @(negedge clk);
      end
    end
    hsl_bus.valid <= 1'b0;
    while (pending_rgb_q.size() != 0) begin
      @(negedge clk);
    end

    burst_left = 0;
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      style         = $urandom_range(0, 9);
      px.hue        = FRAC_BITS'($urandom_range(0, ONE_LEVEL - 1));
      px.saturation = (style == 0) ? '0 : random_level(style - 1);
      px.lightness  = random_level($urandom_range(0, 4));
      offer_pixel(px, 1'b0, none);
      if (n == 300) begin
        // The output holds off while the input keeps pushing back to back.
        hold_requests++;
        burst_left = 60;
      end
      if (n == 700) begin
        hsl_bus.valid <= 1'b0;
        while (pending_rgb_q.size() != 0) begin
          @(negedge clk);
        end
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 40);
        hsl_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    hsl_bus.valid <= 1'b0;

    while (pending_rgb_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (2 * STAGES + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- hsl_to_rgb.f -----
src/hsl_pkg.sv
src/hsl_in_if.sv
src/hsl_out_if.sv
src/hsl_ctrl.sv
src/hsl_front.sv
src/hsl_chan.sv
src/hsl_to_rgb.sv
sim/hsl_to_rgb_tb.sv
